>>> sv/rmq_pkg.sv
// Shared constants and stage-to-stage structs for the rotation-matrix to quaternion pipeline.
`timescale 1ns / 1ps
`default_nettype none
package rmq_pkg;

  localparam int FracBits = 14;
  localparam int SqrtSteps = 16;   // result bits of the square root
  localparam int DivSteps = 32;    // numerator bits of the divider
  localparam logic [31:0] QuatLim = 32'(1) << FracBits;

  // component codes in x, y, z, w order
  localparam logic [1:0] COMP_X = 2'd0;
  localparam logic [1:0] COMP_Y = 2'd1;
  localparam logic [1:0] COMP_Z = 2'd2;
  localparam logic [1:0] COMP_W = 2'd3;

  // sideband carried beside the square-root pipeline
  typedef struct packed {
    logic signed [17:0] off0;
    logic signed [17:0] off1;
    logic signed [17:0] off2;
    logic [1:0]         big;
    logic               degen;
  } sq_side_t;

  // sideband carried beside the divider pipeline
  typedef struct packed {
    logic [2:0]  neg;
    logic [15:0] half;
    logic [1:0]  big;
    logic        degen;
  } dv_side_t;

endpackage
`default_nettype wire

>>> sv/rmq_front.sv
// Front stage: trace, branch select, square-root operand and off-branch terms.
`timescale 1ns / 1ps
`default_nettype none
module rmq_front import rmq_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               en_i,
  input  wire logic               valid_i,
  input  wire logic signed [15:0] r00_i,
  input  wire logic signed [15:0] r01_i,
  input  wire logic signed [15:0] r02_i,
  input  wire logic signed [15:0] r10_i,
  input  wire logic signed [15:0] r11_i,
  input  wire logic signed [15:0] r12_i,
  input  wire logic signed [15:0] r20_i,
  input  wire logic signed [15:0] r21_i,
  input  wire logic signed [15:0] r22_i,
  output logic                    valid_o,
  output logic [31:0]             rad_o,
  output sq_side_t                side_o
);

  logic signed [18:0] a00, a11, a22, trace, arg;
  logic               valid_q;
  logic [31:0]        rad_d, rad_q;
  sq_side_t           side_d, side_q;

  assign a00 = 19'(r00_i);
  assign a11 = 19'(r11_i);
  assign a22 = 19'(r22_i);
  assign trace = a00 + a11 + a22;

  // branch select and terms
  always_comb begin
    side_d = '0;
    if (trace > 0) begin
      arg = 19'(QuatLim) + trace;
      side_d.big  = COMP_W;
      side_d.off0 = 18'(r21_i) - 18'(r12_i);
      side_d.off1 = 18'(r02_i) - 18'(r20_i);
      side_d.off2 = 18'(r10_i) - 18'(r01_i);
    end else if (r00_i > r11_i && r00_i > r22_i) begin
      arg = 19'(QuatLim) + a00 - a11 - a22;
      side_d.big  = COMP_X;
      side_d.off0 = 18'(r01_i) + 18'(r10_i);
      side_d.off1 = 18'(r02_i) + 18'(r20_i);
      side_d.off2 = 18'(r21_i) - 18'(r12_i);
    end else if (r11_i > r22_i) begin
      arg = 19'(QuatLim) + a11 - a00 - a22;
      side_d.big  = COMP_Y;
      side_d.off0 = 18'(r01_i) + 18'(r10_i);
      side_d.off1 = 18'(r12_i) + 18'(r21_i);
      side_d.off2 = 18'(r02_i) - 18'(r20_i);
    end else begin
      arg = 19'(QuatLim) + a22 - a00 - a11;
      side_d.big  = COMP_Z;
      side_d.off0 = 18'(r02_i) + 18'(r20_i);
      side_d.off1 = 18'(r12_i) + 18'(r21_i);
      side_d.off2 = 18'(r10_i) - 18'(r01_i);
    end
    side_d.degen = (arg <= 0);
    rad_d = side_d.degen ? '0 : (32'(arg[17:0]) << FracBits);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rad_q  <= rad_d;
      side_q <= side_d;
    end
  end

  assign valid_o = valid_q;
  assign rad_o   = rad_q;
  assign side_o  = side_q;

endmodule
`default_nettype wire

>>> sv/rmq_sqrt.sv
// Integer square root, one result bit per pipeline stage.
`timescale 1ns / 1ps
`default_nettype none
module rmq_sqrt import rmq_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        en_i,
  input  wire logic        valid_i,
  input  wire logic [31:0] rad_i,
  input  wire sq_side_t    side_i,
  output logic             valid_o,
  output logic [15:0]      root_o,
  output sq_side_t         side_o
);

  logic [SqrtSteps-1:0] valid_q;
  logic [31:0]          rem_q [SqrtSteps];
  logic [31:0]          res_q [SqrtSteps];
  sq_side_t             side_q [SqrtSteps];

  for (genvar s = 0; s < SqrtSteps; s++) begin : g_step
    logic [31:0] rem_in, res_in, bitv, trial, rem_d, res_d;
    logic        vin;
    sq_side_t    sin;

    if (s == 0) begin : g_first
      assign rem_in = rad_i;
      assign res_in = '0;
      assign vin    = valid_i;
      assign sin    = side_i;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign res_in = res_q[s-1];
      assign vin    = valid_q[s-1];
      assign sin    = side_q[s-1];
    end

    // one restoring step with weight 4^(steps-1-s)
    assign bitv  = 32'(1) << (2 * (SqrtSteps - 1 - s));
    assign trial = res_in + bitv;
    always_comb begin
      if (rem_in >= trial) begin
        rem_d = rem_in - trial;
        res_d = (res_in >> 1) + bitv;
      end else begin
        rem_d = rem_in;
        res_d = res_in >> 1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s] <= 1'b0;
      end else if (en_i) begin
        valid_q[s] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s]  <= rem_d;
        res_q[s]  <= res_d;
        side_q[s] <= sin;
      end
    end
  end

  assign valid_o = valid_q[SqrtSteps-1];
  assign root_o  = res_q[SqrtSteps-1][15:0];
  assign side_o  = side_q[SqrtSteps-1];

endmodule
`default_nettype wire

>>> sv/rmq_div.sv
// Three-lane restoring divider for (d * ONE + r) / (2r), one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module rmq_div import rmq_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        en_i,
  input  wire logic        valid_i,
  input  wire logic [15:0] root_i,
  input  wire sq_side_t    side_i,
  output logic             valid_o,
  output logic [31:0]      quo0_o,
  output logic [31:0]      quo1_o,
  output logic [31:0]      quo2_o,
  output dv_side_t         side_o
);

  logic signed [17:0] off [3];
  logic [31:0]        num_d [3];
  dv_side_t           pside_d;

  // prep stage: magnitudes, rounding term, divisor
  logic               pvalid_q;
  logic [31:0]        pnum_q [3];
  logic [16:0]        pden_q;
  dv_side_t           pside_q;

  assign off[0] = side_i.off0;
  assign off[1] = side_i.off1;
  assign off[2] = side_i.off2;

  always_comb begin
    logic [17:0] mag;
    pside_d = '0;
    for (int l = 0; l < 3; l++) begin
      mag = off[l][17] ? 18'(-off[l]) : 18'(off[l]);
      num_d[l] = (32'(mag) << FracBits) + 32'(root_i);
      pside_d.neg[l] = off[l][17];
    end
    pside_d.half  = 16'((17'(root_i) + 17'd1) >> 1);
    pside_d.big   = side_i.big;
    pside_d.degen = side_i.degen;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pvalid_q <= 1'b0;
    end else if (en_i) begin
      pvalid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pnum_q  <= num_d;
      pden_q  <= {root_i, 1'b0};
      pside_q <= pside_d;
    end
  end

  // long-division stages
  logic [DivSteps-1:0] valid_q;
  logic [31:0]         num_q [DivSteps][3];
  logic [31:0]         quo_q [DivSteps][3];
  logic [16:0]         rem_q [DivSteps][3];
  logic [16:0]         den_q [DivSteps];
  dv_side_t            side_q [DivSteps];

  for (genvar s = 0; s < DivSteps; s++) begin : g_step
    logic        vin;
    logic [16:0] din;
    dv_side_t    sin;
    logic [31:0] nin [3];
    logic [31:0] qin [3];
    logic [16:0] rin [3];
    logic [31:0] num_n [3];
    logic [31:0] quo_n [3];
    logic [16:0] rem_n [3];

    if (s == 0) begin : g_first
      assign vin = pvalid_q;
      assign din = pden_q;
      assign sin = pside_q;
      assign nin = pnum_q;
      always_comb begin
        for (int l = 0; l < 3; l++) begin
          qin[l] = '0;
          rin[l] = '0;
        end
      end
    end else begin : g_next
      assign vin = valid_q[s-1];
      assign din = den_q[s-1];
      assign sin = side_q[s-1];
      assign nin = num_q[s-1];
      assign qin = quo_q[s-1];
      assign rin = rem_q[s-1];
    end

    always_comb begin
      logic [17:0] sh;
      for (int l = 0; l < 3; l++) begin
        sh = {rin[l], nin[l][31]};
        num_n[l] = nin[l] << 1;
        if (sh >= 18'(din)) begin
          rem_n[l] = 17'(sh - 18'(din));
          quo_n[l] = {qin[l][30:0], 1'b1};
        end else begin
          rem_n[l] = sh[16:0];
          quo_n[l] = {qin[l][30:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s] <= 1'b0;
      end else if (en_i) begin
        valid_q[s] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        num_q[s]  <= num_n;
        quo_q[s]  <= quo_n;
        rem_q[s]  <= rem_n;
        den_q[s]  <= din;
        side_q[s] <= sin;
      end
    end
  end

  assign valid_o = valid_q[DivSteps-1];
  assign quo0_o  = quo_q[DivSteps-1][0];
  assign quo1_o  = quo_q[DivSteps-1][1];
  assign quo2_o  = quo_q[DivSteps-1][2];
  assign side_o  = side_q[DivSteps-1];

endmodule
`default_nettype wire

>>> sv/rotation_matrix_to_quaternion.sv
// Top level: rotation matrix to unit quaternion, fully pipelined.
//
//   channel | direction | handshake                 | word
//   in      | input     | in_valid_i / in_ready_o   | r00_i .. r22_i
//   out     | output    | out_valid_o / out_ready_i | quat_x_o .. quat_w_o, degenerate_o
//
// The data path runs through 1 front stage, 16 square-root stages, 1 divider prep stage,
// 32 long-division stages and the output register. One word is taken per cycle while
// the output is not stalled. Reset clears only the valid bits. When the output word is
// held the whole pipeline freezes, so nothing is dropped or repeated.
`timescale 1ns / 1ps
`default_nettype none
module rotation_matrix_to_quaternion import rmq_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic signed [15:0] r00_i,
  input  wire logic signed [15:0] r01_i,
  input  wire logic signed [15:0] r02_i,
  input  wire logic signed [15:0] r10_i,
  input  wire logic signed [15:0] r11_i,
  input  wire logic signed [15:0] r12_i,
  input  wire logic signed [15:0] r20_i,
  input  wire logic signed [15:0] r21_i,
  input  wire logic signed [15:0] r22_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic signed [15:0]      quat_x_o,
  output logic signed [15:0]      quat_y_o,
  output logic signed [15:0]      quat_z_o,
  output logic signed [15:0]      quat_w_o,
  output logic                    degenerate_o
);

  logic        en;
  logic        f_valid, s_valid, d_valid;
  logic [31:0] f_rad;
  sq_side_t    f_side, s_side;
  logic [15:0] s_root;
  logic [31:0] quo [3];
  dv_side_t    d_side;

  // pipeline advances whenever the output register can take a word
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  rmq_front u_front (
    .clk_i, .rst_ni, .en_i(en), .valid_i(in_valid_i),
    .r00_i, .r01_i, .r02_i, .r10_i, .r11_i, .r12_i, .r20_i, .r21_i, .r22_i,
    .valid_o(f_valid), .rad_o(f_rad), .side_o(f_side)
  );

  rmq_sqrt u_sqrt (
    .clk_i, .rst_ni, .en_i(en), .valid_i(f_valid), .rad_i(f_rad), .side_i(f_side),
    .valid_o(s_valid), .root_o(s_root), .side_o(s_side)
  );

  rmq_div u_div (
    .clk_i, .rst_ni, .en_i(en), .valid_i(s_valid), .root_i(s_root), .side_i(s_side),
    .valid_o(d_valid), .quo0_o(quo[0]), .quo1_o(quo[1]), .quo2_o(quo[2]),
    .side_o(d_side)
  );

  // saturate, sign and place components
  logic [15:0] lane [3];
  logic [15:0] comp_d [4];
  logic [15:0] half_sat;
  logic        valid_q, degen_q;
  logic [15:0] comp_q [4];

  always_comb begin
    logic [15:0] mag;
    for (int l = 0; l < 3; l++) begin
      mag = (quo[l] > QuatLim) ? QuatLim[15:0] : quo[l][15:0];
      lane[l] = d_side.neg[l] ? 16'(-mag) : mag;
    end
    half_sat = (32'(d_side.half) > QuatLim) ? QuatLim[15:0] : d_side.half;
    for (int c = 0; c < 4; c++) begin
      if (d_side.degen) begin
        comp_d[c] = '0;
      end else if (2'(c) == d_side.big) begin
        comp_d[c] = half_sat;
      end else if (2'(c) < d_side.big) begin
        comp_d[c] = lane[c];
      end else begin
        comp_d[c] = lane[c-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en) begin
      valid_q <= d_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      comp_q  <= comp_d;
      degen_q <= d_side.degen;
    end
  end

  assign out_valid_o  = valid_q;
  assign quat_x_o     = comp_q[COMP_X];
  assign quat_y_o     = comp_q[COMP_Y];
  assign quat_z_o     = comp_q[COMP_Z];
  assign quat_w_o     = comp_q[COMP_W];
  assign degenerate_o = degen_q;

  // degenerate words carry an all-zero quaternion
  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && degenerate_o |->
      quat_x_o == 0 && quat_y_o == 0 && quat_z_o == 0 && quat_w_o == 0)
    else $error("degenerate word with nonzero quaternion");

  // every component stays within the saturation bounds
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      quat_x_o <= 16384 && quat_x_o >= -16384 && quat_y_o <= 16384 &&
      quat_y_o >= -16384 && quat_z_o <= 16384 && quat_z_o >= -16384 &&
      quat_w_o <= 16384 && quat_w_o >= -16384)
    else $error("quaternion component out of range");

  // a held output word freezes the input side
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input taken while output stalled");

endmodule
`default_nettype wire
